// ----- sv/crc_pkg.sv -----
// Shared types and constants for the channel range calibrator.
`default_nettype none

package crc_pkg;

   // Default sizing of the core
   localparam int MAX_CHANNELS_DEF = 32;
   localparam int VALUE_BITS_DEF   = 16;
   localparam int SOURCE_COUNT_DEF = 32;

   // Field widths
   localparam int ChanBits   = 5;
   localparam int CountBits  = 6;
   localparam int DataBits   = 32;
   localparam int ShiftBits  = 5;
   localparam int CsrIdxBits = 1;

   // Request opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   // Response kinds
   localparam logic KIND_ECHO = 1'b0;
   localparam logic KIND_CAL  = 1'b1;

   // Register indexes
   localparam logic [CsrIdxBits-1:0] REG_CHANNEL_COUNT = 1'b0;
   localparam logic [CsrIdxBits-1:0] REG_SOURCE_MASK   = 1'b1;

   // Register reset values
   localparam logic [CountBits-1:0] CHANNEL_COUNT_RST = 6'd32;
   localparam logic [DataBits-1:0]  SOURCE_MASK_RST   = 32'hFFFF_FFFF;

   // Store reset values
   localparam logic [DataBits-1:0] LOW_RST  = 32'hFFFF_FFFF;
   localparam logic [DataBits-1:0] HIGH_RST = 32'h0000_0000;

   // Largest shift the search may reach
   localparam logic [ShiftBits-1:0] SHIFT_MAX = 5'd31;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SREAD,
      ST_SUPDATE,
      ST_ECHO,
      ST_COUNT,
      ST_LOAD,
      ST_DIFF,
      ST_SHIFT,
      ST_EMIT,
      ST_CLEAR
   } state_type;

endpackage

`default_nettype wire

// ----- sv/channel_range_calibrator_core.sv -----
// Channel range calibrator: per-channel min/max tracking and calibration walk.
// Sample request: read, update, then response loaded in ECHO once output is free; next request
//   taken on return to idle. Finish request: mask bit counting over SOURCE_COUNT bits, then per
//   emitted channel LOAD, DIFF, up to 31 shift steps in the shared shift/compare unit, EMIT.
// One request in flight; ready the cycle after an echo load, or after the last cal via CLEAR.
// Synchronous active-high reset: registers to reset values, range store emptied (valid bits).
`default_nettype none

module channel_range_calibrator_core #(
   parameter int MAX_CHANNELS = crc_pkg::MAX_CHANNELS_DEF,
   parameter int VALUE_BITS   = crc_pkg::VALUE_BITS_DEF,
   parameter int SOURCE_COUNT = crc_pkg::SOURCE_COUNT_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_opcode,
   input  wire logic [crc_pkg::ChanBits-1:0]         req_channel,
   input  wire logic [crc_pkg::DataBits-1:0]         req_sample,
   // response channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_kind,
   output logic [crc_pkg::ChanBits-1:0]              rsp_out_channel,
   output logic [crc_pkg::DataBits-1:0]              rsp_echo,
   output logic [crc_pkg::ShiftBits-1:0]             rsp_shift,
   output logic [crc_pkg::DataBits-1:0]              rsp_offset,
   output logic                                      rsp_last,
   // register write channel
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [crc_pkg::CsrIdxBits-1:0]       csr_index,
   input  wire logic [crc_pkg::DataBits-1:0]         csr_wdata
);

   localparam int IdxW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam logic [crc_pkg::DataBits-1:0] Full =
      crc_pkg::DataBits'((64'd1 << VALUE_BITS) - 64'd1);
   localparam logic [crc_pkg::DataBits-1:0] Margin = Full / 4;
   localparam logic [crc_pkg::DataBits-1:0] Target = Full - 2 * Margin;
   localparam logic [crc_pkg::CountBits-1:0] MaxCnt = crc_pkg::CountBits'(MAX_CHANNELS);
   localparam logic [crc_pkg::CountBits-1:0] LastPos = crc_pkg::CountBits'(SOURCE_COUNT - 1);

   // Configuration registers
   logic [crc_pkg::CountBits-1:0] chan_count_ff;
   logic [crc_pkg::DataBits-1:0]  src_mask_ff;

   // Range store with per-channel valid bits
   logic [crc_pkg::DataBits-1:0] low_mem  [MAX_CHANNELS];
   logic [crc_pkg::DataBits-1:0] high_mem [MAX_CHANNELS];
   logic [MAX_CHANNELS-1:0]      vld_ff;

   // Sequencer and datapath
   crc_pkg::state_type state_ff, state_in;
   logic [crc_pkg::ChanBits-1:0]  ch_ff;
   logic [crc_pkg::DataBits-1:0]  smp_ff;
   logic [crc_pkg::CountBits-1:0] pos_ff;
   logic [crc_pkg::CountBits-1:0] pop_ff;
   logic [crc_pkg::CountBits-1:0] walk_ff;
   logic [crc_pkg::DataBits-1:0]  lo_ff, hi_ff;
   logic [crc_pkg::DataBits-1:0]  rng_ff;
   logic [crc_pkg::DataBits-1:0]  off_ff;
   logic [crc_pkg::ShiftBits-1:0] sh_ff;

   // Output register
   logic                          rsp_valid_ff;
   logic                          rsp_kind_ff;
   logic [crc_pkg::ChanBits-1:0]  rsp_chan_ff;
   logic [crc_pkg::DataBits-1:0]  rsp_echo_ff;
   logic [crc_pkg::ShiftBits-1:0] rsp_shift_ff;
   logic [crc_pkg::DataBits-1:0]  rsp_off_ff;
   logic                          rsp_last_ff;

   logic [crc_pkg::CountBits-1:0] cnt_eff;
   logic [crc_pkg::CountBits-1:0] limit;
   logic [IdxW-1:0]               rd_idx;
   logic [IdxW-1:0]               ch_idx;
   logic                          out_free;
   logic                          req_take;
   logic                          in_use;
   logic                          shift_more;
   logic                          load_echo;
   logic                          load_cal;

   assign cnt_eff    = (chan_count_ff > MaxCnt) ? MaxCnt : chan_count_ff;
   assign limit      = (pop_ff < cnt_eff) ? pop_ff : cnt_eff;
   assign ch_idx     = ch_ff[IdxW-1:0];
   assign rd_idx     = (state_ff == crc_pkg::ST_LOAD) ? walk_ff[IdxW-1:0] : ch_idx;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_take   = req_valid && req_ready;
   assign in_use     = {1'b0, ch_ff} < cnt_eff;
   assign shift_more = (sh_ff != crc_pkg::SHIFT_MAX) && (rng_ff > Target);
   assign csr_ready  = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         chan_count_ff <= crc_pkg::CHANNEL_COUNT_RST;
         src_mask_ff   <= crc_pkg::SOURCE_MASK_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            crc_pkg::REG_CHANNEL_COUNT: chan_count_ff <= csr_wdata[crc_pkg::CountBits-1:0];
            crc_pkg::REG_SOURCE_MASK:   src_mask_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and handshake
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      load_echo = 1'b0;
      load_cal  = 1'b0;
      case (state_ff)
         crc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = (req_opcode == crc_pkg::OP_FINISH) ? crc_pkg::ST_COUNT
                                                             : crc_pkg::ST_SREAD;
            end
         end
         crc_pkg::ST_SREAD:   state_in = crc_pkg::ST_SUPDATE;
         crc_pkg::ST_SUPDATE: state_in = crc_pkg::ST_ECHO;
         crc_pkg::ST_ECHO: begin
            if (out_free) begin
               load_echo = 1'b1;
               state_in  = crc_pkg::ST_IDLE;
            end
         end
         crc_pkg::ST_COUNT: begin
            if (pos_ff == LastPos) state_in = crc_pkg::ST_LOAD;
         end
         crc_pkg::ST_LOAD: begin
            state_in = (walk_ff < limit) ? crc_pkg::ST_DIFF : crc_pkg::ST_CLEAR;
         end
         crc_pkg::ST_DIFF: state_in = crc_pkg::ST_SHIFT;
         crc_pkg::ST_SHIFT: begin
            if (!shift_more) state_in = crc_pkg::ST_EMIT;
         end
         crc_pkg::ST_EMIT: begin
            if (out_free) begin
               load_cal = 1'b1;
               state_in = crc_pkg::ST_LOAD;
            end
         end
         crc_pkg::ST_CLEAR: state_in = crc_pkg::ST_IDLE;
         default: state_in = crc_pkg::ST_IDLE;
      endcase
   end

   // Request capture, store read, mask bit counting and the shared subtract/shift unit
   always_ff @(posedge clock) begin
      if (req_take) begin
         ch_ff  <= req_channel;
         smp_ff <= req_sample;
         pos_ff <= '0;
         pop_ff <= '0;
         walk_ff <= '0;
      end
      case (state_ff)
         crc_pkg::ST_SREAD, crc_pkg::ST_LOAD: begin
            lo_ff <= vld_ff[rd_idx] ? low_mem[rd_idx]  : crc_pkg::LOW_RST;
            hi_ff <= vld_ff[rd_idx] ? high_mem[rd_idx] : crc_pkg::HIGH_RST;
         end
         crc_pkg::ST_COUNT: begin
            pop_ff <= pop_ff + crc_pkg::CountBits'(src_mask_ff[pos_ff[4:0]]);
            pos_ff <= pos_ff + 1'b1;
         end
         crc_pkg::ST_DIFF: begin
            rng_ff <= hi_ff - lo_ff;
            off_ff <= (lo_ff > Margin) ? (lo_ff - Margin) : '0;
            sh_ff  <= '0;
         end
         crc_pkg::ST_SHIFT: begin
            if (shift_more) begin
               rng_ff <= rng_ff >> 1;
               sh_ff  <= sh_ff + 1'b1;
            end
         end
         crc_pkg::ST_EMIT: begin
            if (out_free) walk_ff <= walk_ff + 1'b1;
         end
         default: ;
      endcase
   end

   // Range store update on an in-use sample
   always_ff @(posedge clock) begin
      if (state_ff == crc_pkg::ST_SUPDATE && in_use) begin
         low_mem[ch_idx]  <= (smp_ff < lo_ff) ? smp_ff : lo_ff;
         high_mem[ch_idx] <= (smp_ff > hi_ff) ? smp_ff : hi_ff;
      end
   end

   // Valid bits: set on write, dropped at reset and after a finish
   always_ff @(posedge clock) begin
      if (reset || state_ff == crc_pkg::ST_CLEAR) begin
         vld_ff <= '0;
      end else if (state_ff == crc_pkg::ST_SUPDATE && in_use) begin
         vld_ff[ch_idx] <= 1'b1;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_echo || load_cal) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_echo) begin
         rsp_kind_ff  <= crc_pkg::KIND_ECHO;
         rsp_chan_ff  <= ch_ff;
         rsp_echo_ff  <= smp_ff;
         rsp_shift_ff <= '0;
         rsp_off_ff   <= '0;
         rsp_last_ff  <= 1'b1;
      end else if (load_cal) begin
         rsp_kind_ff  <= crc_pkg::KIND_CAL;
         rsp_chan_ff  <= walk_ff[crc_pkg::ChanBits-1:0];
         rsp_echo_ff  <= '0;
         rsp_shift_ff <= sh_ff;
         rsp_off_ff   <= off_ff;
         rsp_last_ff  <= (walk_ff + 1'b1) == limit;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_out_channel = rsp_chan_ff;
   assign rsp_echo        = rsp_echo_ff;
   assign rsp_shift       = rsp_shift_ff;
   assign rsp_offset      = rsp_off_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

`default_nettype wire
